FILE: design/idsf_pkg.sv
package idsf_pkg;

  // Default marker length and the length of the marker text
  localparam int MARKER_LEN_DEF = 12;
  localparam int MARK_TEXT_LEN  = 12;

  // Byte that opens every marker
  localparam logic [7:0] START_CHAR = 8'h25;

  // Marker text that opens a captured region
  localparam logic [7:0] BEGIN_MARK [MARK_TEXT_LEN] = '{
    8'h25, 8'h50, 8'h43, 8'h41, 8'h50, 8'h5F,
    8'h42, 8'h45, 8'h47, 8'h49, 8'h4E, 8'h25
  };

  // Marker text that closes a captured region
  localparam logic [7:0] CLOSE_MARK [MARK_TEXT_LEN] = '{
    8'h25, 8'h50, 8'h43, 8'h41, 8'h50, 8'h5F,
    8'h43, 8'h4C, 8'h4F, 8'h53, 8'h45, 8'h25
  };

  // Commands from controller to datapath
  typedef struct packed {
    logic take_in;    // input item accepted this cycle
    logic rep_step;   // emit one buffered byte
    logic emit_hold;  // emit the held input byte
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;      // output register can load this cycle
    logic start_replay;  // incoming byte breaks a partial match, replay needed
    logic rep_last;      // replay index at last buffered byte
    logic hold_pct;      // held byte is the start character
  } dp_stat_t;

  // True when byte b equals the selected marker at position pos
  function automatic logic mark_has(input logic is_close, input logic [3:0] pos,
                                    input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    if (pos < 4'(MARK_TEXT_LEN)) begin
      if (is_close) hit = (CLOSE_MARK[pos] == b);
      else          hit = (BEGIN_MARK[pos] == b);
    end
    return hit;
  endfunction

endpackage

FILE: design/idsf_dp.sv
module idsf_dp
  import idsf_pkg::*;
#(
  parameter int MARKER_LEN = MARKER_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       m_tready,
  input  dp_cmd_t    cmd,
  output dp_stat_t   st,
  output logic       m_tvalid,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  localparam int CW = $clog2(MARKER_LEN + 1);
  localparam int IW = $clog2(MARKER_LEN);

  // Match buffer and match tracking
  logic [7:0]    mbuf [MARKER_LEN];
  logic [CW-1:0] cnt, cnt_next;
  logic          mode, mode_next;
  logic          beg_ok, beg_ok_next;
  logic          cls_ok, cls_ok_next;
  logic [7:0]    hold, hold_next;
  logic [IW-1:0] rep_idx, rep_idx_next;

  // Output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  // Datapath controls
  logic          load;
  logic [7:0]    load_byte;
  logic          load_last;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_data;

  logic          hit_beg, hit_cls, in_match, start_replay, rep_last, hold_pct, out_free;
  logic [CW-1:0] cnt_inc;
  logic          beg_new, cls_new;

  // Marker compare at the current position
  assign hit_beg      = mark_has(1'b0, 4'(cnt), rx_byte);
  assign hit_cls      = mark_has(1'b1, 4'(cnt), rx_byte);
  assign in_match     = (cnt != '0) && (hit_beg || hit_cls);
  assign start_replay = (cnt != '0) && !in_match && !mode;
  assign rep_last     = (rep_idx == IW'(cnt - 1'b1));
  assign hold_pct     = (hold == START_CHAR);
  assign out_free     = !out_valid || m_tready;
  assign cnt_inc      = cnt + 1'b1;
  assign beg_new      = beg_ok & hit_beg;
  assign cls_new      = cls_ok & hit_cls;

  assign st.out_free     = out_free;
  assign st.start_replay = start_replay;
  assign st.rep_last     = rep_last;
  assign st.hold_pct     = hold_pct;

  // Next-state and output load selection
  always_comb begin
    cnt_next     = cnt;
    mode_next    = mode;
    beg_ok_next  = beg_ok;
    cls_ok_next  = cls_ok;
    hold_next    = hold;
    rep_idx_next = rep_idx;
    load         = 1'b0;
    load_byte    = rx_byte;
    load_last    = 1'b1;
    wr_en        = 1'b0;
    wr_addr      = IW'(cnt);
    wr_data      = rx_byte;
    if (cmd.take_in) begin
      hold_next    = rx_byte;
      rep_idx_next = '0;
      if (in_match) begin
        wr_en       = 1'b1;
        beg_ok_next = beg_new;
        cls_ok_next = cls_new;
        if (cnt_inc == CW'(MARKER_LEN)) begin
          cnt_next = '0;
          if (beg_new)      mode_next = 1'b1;
          else if (cls_new) mode_next = 1'b0;
        end else begin
          cnt_next = cnt_inc;
        end
      end else if (!start_replay) begin
        if (rx_byte == START_CHAR) begin
          wr_en       = 1'b1;
          wr_addr     = '0;
          cnt_next    = CW'(1);
          beg_ok_next = 1'b1;
          cls_ok_next = 1'b1;
        end else begin
          cnt_next = '0;
          load     = !mode;
        end
      end
    end else if (cmd.rep_step) begin
      // buffered byte itself is picked in the output register block
      load         = 1'b1;
      load_last    = rep_last && hold_pct;
      rep_idx_next = rep_idx + 1'b1;
      if (rep_last) begin
        if (hold_pct) begin
          wr_en       = 1'b1;
          wr_addr     = '0;
          wr_data     = hold;
          cnt_next    = CW'(1);
          beg_ok_next = 1'b1;
          cls_ok_next = 1'b1;
        end else begin
          cnt_next = '0;
        end
      end
    end else if (cmd.emit_hold) begin
      load      = 1'b1;
      load_byte = hold;
      load_last = 1'b1;
    end
  end

  // Match buffer write
  always_ff @(posedge clk) begin
    if (wr_en) mbuf[wr_addr] <= wr_data;
  end

  // Payload state
  always_ff @(posedge clk) begin
    beg_ok  <= beg_ok_next;
    cls_ok  <= cls_ok_next;
    hold    <= hold_next;
    rep_idx <= rep_idx_next;
    if (load) begin
      out_byte <= cmd.rep_step ? mbuf[rep_idx] : load_byte;
      out_last <= load_last;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      mode      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      mode <= mode_next;
      if (load)          out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

  // Partial match never holds a full marker length
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt < CW'(MARKER_LEN))
    else $error("match count reached marker length");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |-> !load)
    else $error("output register overwritten while stalled");

  // Capture mode only moves on an accepted item
  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.take_in |=> $stable(mode))
    else $error("capture mode changed without input");

endmodule

FILE: design/idsf_ctrl.sv
module idsf_ctrl
  import idsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  dp_stat_t st,
  output dp_cmd_t  cmd,
  output logic     s_tready
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REPLAY = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0] state, state_next;

  assign s_tready = (state == S_IDLE) && st.out_free;

  // Sequencing of accept, replay and held-byte emit
  always_comb begin
    state_next    = state;
    cmd.take_in   = 1'b0;
    cmd.rep_step  = 1'b0;
    cmd.emit_hold = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && st.out_free) begin
          cmd.take_in = 1'b1;
          if (st.start_replay) state_next = S_REPLAY;
        end
      end
      S_REPLAY: begin
        if (st.out_free) begin
          cmd.rep_step = 1'b1;
          if (st.rep_last) state_next = st.hold_pct ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_hold = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take_in, cmd.rep_step, cmd.emit_hold}))
    else $error("conflicting datapath commands");

  // A broken match goes into replay
  a_enter_replay: assert property (@(posedge clk) disable iff (rst)
    cmd.take_in && st.start_replay |=> state == S_REPLAY)
    else $error("replay not started");

  // Replay continues until its last byte
  a_replay_run: assert property (@(posedge clk) disable iff (rst)
    state == S_REPLAY && cmd.rep_step && !st.rep_last |=> state == S_REPLAY)
    else $error("replay left early");

endmodule

FILE: design/inband_delimiter_stream_filter.sv
// Channel   Group                      Payload
// input     s_tvalid/s_tready/s_tdata  s_tdata[7:0] rx_byte
// output    m_tvalid/m_tready/m_tdata  m_tdata[7:0] out_byte, m_tlast last_of_run
//
// An item that is buffered, swallowed or passed on directly needs no replay.
// An item that breaks a partial marker match while passing replays the match
// buffer one byte per cycle while the output is free, then emits itself unless
// it is the start character, which opens a new match; capture mode sends none.
// rst is synchronous; no clearing pass, the block takes items the cycle after.
// A stall on m_tready holds the output register and pauses the replay.
module inband_delimiter_stream_filter
  import idsf_pkg::*;
#(
  parameter int MARKER_LEN = MARKER_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  idsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .st       (st),
    .cmd      (cmd),
    .s_tready (s_tready)
  );

  idsf_dp #(
    .MARKER_LEN (MARKER_LEN)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (s_tdata),
    .m_tready (m_tready),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: test/inband_delimiter_stream_filter_tb.sv
module inband_delimiter_stream_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idsf_pkg::*;

  localparam int MLEN = MARKER_LEN_DEF;

  // Expected byte stream of the filter, rebuilt from every accepted rx item
  class idsf_scoreboard;
    logic [7:0]  held [MLEN];
    int unsigned held_cnt;
    bit          capturing;
    logic [7:0]  exp_byte [$];
    logic        exp_last [$];
    int errors, n_in, n_out, n_begin, n_close, n_mixed, n_replay, n_discard;

    function new();
      held_cnt  = 0;
      capturing = 1'b0;
      errors    = 0;
      n_in      = 0;
      n_out     = 0;
      n_begin   = 0;
      n_close   = 0;
      n_mixed   = 0;
      n_replay  = 0;
      n_discard = 0;
    endfunction

    // Byte b may continue a partial marker at position pos
    function bit fits_marker(int unsigned pos, logic [7:0] b);
      if (pos >= MARK_TEXT_LEN) return 1'b0;
      return (BEGIN_MARK[pos] == b) || (CLOSE_MARK[pos] == b);
    endfunction

    function bit held_equals(bit close);
      for (int i = 0; i < MLEN; i++) begin
        if (i >= MARK_TEXT_LEN) return 1'b0;
        if (close && held[i] != CLOSE_MARK[i]) return 1'b0;
        if (!close && held[i] != BEGIN_MARK[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(logic [7:0] b);
      logic [7:0] run [$];
      n_in++;
      if (held_cnt >= MLEN) held_cnt = 0;
      if (held_cnt != 0) begin
        if (fits_marker(held_cnt, b)) begin
          held[held_cnt] = b;
          held_cnt++;
          if (held_cnt >= MLEN) begin
            if (held_equals(1'b0)) begin
              capturing = 1'b1;
              n_begin++;
            end else if (held_equals(1'b1)) begin
              capturing = 1'b0;
              n_close++;
            end else begin
              n_mixed++;
            end
            held_cnt = 0;
          end
          return;
        end
        // partial match broken: replay when passing, drop when capturing
        if (!capturing) begin
          for (int i = 0; i < held_cnt; i++) run.push_back(held[i]);
          n_replay++;
        end else begin
          n_discard++;
        end
        held_cnt = 0;
      end
      if (b == START_CHAR) begin
        held[0]  = b;
        held_cnt = 1;
      end else if (!capturing) begin
        run.push_back(b);
      end
      foreach (run[i]) begin
        exp_byte.push_back(run[i]);
        exp_last.push_back(i == run.size() - 1);
      end
    endfunction

    function void check_result(logic [7:0] b, logic last);
      logic [7:0] eb;
      logic       el;
      n_out++;
      if (exp_byte.size() == 0) begin
        $error("unexpected item: out_byte %h last_of_run %b", b, last);
        errors++;
        return;
      end
      eb = exp_byte.pop_front();
      el = exp_last.pop_front();
      if (b !== eb) begin
        $error("out_byte mismatch: expected %h, actual %h", eb, b);
        errors++;
      end
      if (last !== el) begin
        $error("last_of_run mismatch: expected %b, actual %b", el, last);
        errors++;
      end
    endfunction

    function int pending();
      return exp_byte.size();
    endfunction

    function void report_leftover();
      if (exp_byte.size() != 0) begin
        $error("%0d expected items never arrived, first out_byte %h",
               exp_byte.size(), exp_byte[0]);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] rx_byte
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] out_byte
  logic       m_tlast;   // last_of_run

  idsf_scoreboard sb = new();

  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left     = 0;
  int items_sent    = 0;

  inband_delimiter_stream_filter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("inband_delimiter_stream_filter verification failed");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Monitor: results are checked before the input of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
      if (s_tvalid && s_tready) sb.note_input(s_tdata);
    end
  end

  task automatic send_rx(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_rx(s[i]);
  endtask

  // kind 0: begin marker, 1: close marker, 2: random mix per position
  task automatic send_marker(input int len, input int kind);
    for (int i = 0; i < len; i++) begin
      if (kind == 0) send_rx(BEGIN_MARK[i]);
      else if (kind == 1) send_rx(CLOSE_MARK[i]);
      else send_rx($urandom_range(1) ? CLOSE_MARK[i] : BEGIN_MARK[i]);
    end
  endtask

  // Partial marker of len bytes, then a byte that cannot continue it
  task automatic send_broken(input int len);
    logic [7:0] brk;
    send_marker(len, 2);
    if (len < MARK_TEXT_LEN - 1 && $urandom_range(2) == 0) begin
      brk = START_CHAR;
    end else begin
      brk = 8'($urandom_range(255));
      while (sb.fits_marker(len, brk)) brk = 8'($urandom_range(255));
    end
    send_rx(brk);
  endtask

  task automatic drain();
    int k;
    k = 0;
    s_tvalid <= 1'b0;
    while (sb.pending() != 0 && k < 20000) begin
      @(posedge clk);
      k++;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int target;
    int r;
    int n;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 14) send_marker(MLEN, 0);
      else if (r < 28) send_marker(MLEN, 1);
      else if (r < 36) send_marker(MLEN, 2);
      else if (r < 64) send_broken($urandom_range(1, MLEN - 1));
      else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(9) == 0) send_rx(START_CHAR);
          else send_rx(8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    m_tready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, markers, mixed marker, breaks in both modes
    send_rx(8'h00);
    send_rx(8'hFF);
    send_text("%P%Q");           // percent after a mismatch restarts buffering
    send_marker(MLEN, 0);        // enter capture
    send_rx(8'h55);              // dropped in capture
    send_text("%PCAx");          // broken partial discarded silently
    send_text("%PCAP_CLOSN%");   // mixed marker, mode unchanged
    send_marker(MLEN, 1);        // leave capture
    send_marker(MLEN - 1, 0);
    send_rx(8'hAA);              // longest replay
    send_text("%PCAP_BEGSE%");   // mixed marker while passing
    drain();

    // No idling, with a long receiver hold-off up front
    hold_left = 300;
    random_phase(75);
    drain();

    send_idle_pct = 54;
    rcv_stall_pct = 0;
    random_phase(75);
    drain();

    send_idle_pct = 0;
    rcv_stall_pct = 54;
    random_phase(75);
    drain();

    send_idle_pct = 26;
    rcv_stall_pct = 26;
    random_phase(75);
    drain();

    sb.report_leftover();
    $display("Run covered %0d rx items and %0d output items over four idling phases.",
             sb.n_in, sb.n_out);
    $display("Markers seen: %0d begin, %0d close, %0d mixed; %0d replays, %0d discards.",
             sb.n_begin, sb.n_close, sb.n_mixed, sb.n_replay, sb.n_discard);
    if (sb.errors == 0) begin
      $display("inband_delimiter_stream_filter verification clean");
    end else begin
      $display("inband_delimiter_stream_filter verification failed");
    end
    $finish;
  end

endmodule
